// ----- hw/rtl/srw_pkg.sv -----
package srw_pkg;

  localparam int SEQ_BITS = 8;
  localparam int LEN_BITS = 10;
  localparam int TAG_BITS = 16;
  localparam int TS_BITS = 32;
  localparam int WIN_BITS = 5;

  localparam logic [WIN_BITS-1:0] RESET_WINDOW = 5'd3;
  // one reply carries at most 32 results, the ack included
  localparam logic [4:0] DELIVER_LIMIT = 5'd31;

  localparam int QPTR_BITS = 1;
  localparam int QDEPTH = 1 << QPTR_BITS;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NACK    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NACK,
    OP_END,
    OP_DATA
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SEQ_BITS-1:0] seq;
    logic [LEN_BITS-1:0] len;
    logic [TAG_BITS-1:0] tag;
    logic [TS_BITS-1:0]  ts;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hw/rtl/selective_repeat_receive_window_core.sv -----
// Selective-repeat receive window. Each input beat is one decoded data packet.
// A truncated packet returns one nack, a zero-length one an end-of-transfer
// marker; any other packet is placed in the reorder store if it falls inside
// the window, then up to 31 in-order stored packets are delivered, followed by a
// cumulative ack (last set on the final beat of each reply). Packets pass
// through a two-entry queue into an executor that owns the store. Each
// delivery first reads the head slot of the store memory through a registered
// read (state S_READ), then loads the beat (state S_DRAIN). The store needs no
// clearing after reset: full flags are flip-flops that reset clears.
// window_size is to be written only while the block is idle; the block itself
// does not enforce it. A value of 0 acts as 1 and values above MAX_WINDOW are
// capped.
module selective_repeat_receive_window_core import srw_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [WIN_BITS-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SEQ_BITS-1:0] seq_num,
  input  logic [LEN_BITS-1:0] payload_len,
  input  logic                truncated,
  input  logic [TAG_BITS-1:0] payload_tag,
  input  logic [TS_BITS-1:0]  timestamp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [LEN_BITS-1:0] out_len,
  output logic [SEQ_BITS-1:0] ack_seq,
  output logic [TS_BITS-1:0]  echo_time,
  output logic [WIN_BITS-1:0] advertised_window,
  output logic                last
);

  logic [WIN_BITS-1:0] window_size;
  q_push_t             push;
  q_status_t           q_status;
  cmd_t                q_cmd;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= RESET_WINDOW;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  srw_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seq_num     (seq_num),
    .payload_len (payload_len),
    .truncated   (truncated),
    .payload_tag (payload_tag),
    .timestamp   (timestamp),
    .q_status    (q_status),
    .push        (push)
  );

  srw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (q_pop),
    .status   (q_status),
    .head_cmd (q_cmd)
  );

  srw_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .window_size       (window_size),
    .q_status          (q_status),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .out_tag           (out_tag),
    .out_len           (out_len),
    .ack_seq           (ack_seq),
    .echo_time         (echo_time),
    .advertised_window (advertised_window),
    .last              (last)
  );

endmodule

// ----- hw/rtl/srw_front.sv -----
module srw_front import srw_pkg::*; (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SEQ_BITS-1:0] seq_num,
  input  logic [LEN_BITS-1:0] payload_len,
  input  logic                truncated,
  input  logic [TAG_BITS-1:0] payload_tag,
  input  logic [TS_BITS-1:0]  timestamp,
  input  q_status_t           q_status,
  output q_push_t             push
);

  op_t op;

  // truncation wins over the end-of-transfer marker
  always_comb begin
    if (truncated) begin
      op = OP_NACK;
    end else if (payload_len == '0) begin
      op = OP_END;
    end else begin
      op = OP_DATA;
    end
  end

  assign in_stall = q_status.full;

  always_comb begin
    push.valid   = in_valid && !q_status.full;
    push.cmd.op  = op;
    push.cmd.seq = seq_num;
    push.cmd.len = payload_len;
    push.cmd.tag = payload_tag;
    push.cmd.ts  = timestamp;
  end

endmodule

// ----- hw/rtl/srw_queue.sv -----
module srw_queue import srw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   push,
  input  logic      pop,
  output q_status_t status,
  output cmd_t      head_cmd
);

  cmd_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign status.full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign status.empty = (count == '0);
  assign head_cmd     = entries[rd_ptr];

  assign do_push = push.valid && !status.full;
  assign do_pop  = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

endmodule

// ----- hw/rtl/srw_back.sv -----
module srw_back import srw_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [WIN_BITS-1:0] window_size,
  input  q_status_t           q_status,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [LEN_BITS-1:0] out_len,
  output logic [SEQ_BITS-1:0] ack_seq,
  output logic [TS_BITS-1:0]  echo_time,
  output logic [WIN_BITS-1:0] advertised_window,
  output logic                last
);

  localparam int SW = $clog2(MAX_WINDOW);
  localparam logic [WIN_BITS-1:0] WIN_CAP =
    (MAX_WINDOW < 31) ? WIN_BITS'(MAX_WINDOW) : 5'd31;
  localparam logic [8:0] STORE_DEPTH = 9'(MAX_WINDOW);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_WINDOW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DRAIN
  } state_t;

  state_t                state;
  cmd_t                  cur;
  logic [SEQ_BITS-1:0]   exp_seq;
  logic [SW-1:0]         head;
  logic [MAX_WINDOW-1:0] full;
  logic [4:0]            cnt;

  logic [LEN_BITS-1:0]   mem_len [MAX_WINDOW];
  logic [TAG_BITS-1:0]   mem_tag [MAX_WINDOW];
  logic [LEN_BITS-1:0]   rd_len;
  logic [TAG_BITS-1:0]   rd_tag;

  logic [WIN_BITS-1:0]   win_floor;
  logic [WIN_BITS-1:0]   win_eff;
  logic [SEQ_BITS-1:0]   off;
  logic                  in_win;
  logic [8:0]            slot_sum;
  logic [8:0]            slot_wrap;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         head_next;
  logic                  out_free;
  logic                  mem_we;
  logic                  beat_load;

  assign win_floor = (window_size == '0) ? WIN_BITS'(1) : window_size;
  assign win_eff   = (win_floor > WIN_CAP) ? WIN_CAP : win_floor;

  // modular offset from the next expected number
  assign off    = cur.seq - exp_seq;
  assign in_win = (off < SEQ_BITS'(win_eff));

  // head + off stays below twice the store depth inside the window
  assign slot_sum  = 9'(head) + 9'(off);
  assign slot_wrap = (slot_sum >= STORE_DEPTH) ? slot_sum - STORE_DEPTH : slot_sum;
  assign slot      = slot_wrap[SW-1:0];
  assign head_next = (head == LAST_SLOT) ? '0 : head + 1'b1;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && !q_status.empty;
  assign mem_we   = (state == S_EXEC) && (cur.op == OP_DATA) && in_win;

  // a new beat is loaded into the output register this cycle
  assign beat_load = out_free &&
    (((state == S_EXEC) && (cur.op == OP_NACK || cur.op == OP_END)) || (state == S_DRAIN));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_len[slot] <= cur.len;
      mem_tag[slot] <= cur.tag;
    end
    rd_len <= mem_len[head];
    rd_tag <= mem_tag[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      exp_seq   <= '0;
      head      <= '0;
      full      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= beat_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            cur   <= q_cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cur.op)
            OP_NACK: begin
              if (out_free) begin
                kind              <= KIND_NACK;
                out_tag           <= '0;
                out_len           <= '0;
                ack_seq           <= cur.seq;
                echo_time         <= cur.ts;
                advertised_window <= win_eff;
                last              <= 1'b1;
                state             <= S_IDLE;
              end
            end
            OP_END: begin
              if (out_free) begin
                kind              <= KIND_END;
                out_tag           <= '0;
                out_len           <= '0;
                ack_seq           <= exp_seq;
                echo_time         <= cur.ts;
                advertised_window <= win_eff;
                last              <= 1'b1;
                state             <= S_IDLE;
              end
            end
            OP_DATA: begin
              if (in_win) begin
                full[slot] <= 1'b1;
              end
              cnt   <= '0;
              state <= S_READ;
            end
            default: state <= S_IDLE;
          endcase
        end
        // head slot data lands in rd_len / rd_tag
        S_READ: state <= S_DRAIN;
        S_DRAIN: begin
          if (out_free) begin
            echo_time         <= cur.ts;
            advertised_window <= win_eff;
            if (full[head] && cnt != DELIVER_LIMIT) begin
              kind       <= KIND_DELIVER;
              out_tag    <= rd_tag;
              out_len    <= rd_len;
              ack_seq    <= exp_seq;
              last       <= 1'b0;
              full[head] <= 1'b0;
              head       <= head_next;
              exp_seq    <= exp_seq + 1'b1;
              cnt        <= cnt + 1'b1;
              state      <= S_READ;
            end else begin
              kind    <= KIND_ACK;
              out_tag <= '0;
              out_len <= '0;
              ack_seq <= exp_seq;
              last    <= 1'b1;
              state   <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/srw_checker.sv -----
module srw_checker import srw_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          kind,
  input logic [TAG_BITS-1:0] out_tag,
  input logic [LEN_BITS-1:0] out_len,
  input logic [SEQ_BITS-1:0] ack_seq,
  input logic [TS_BITS-1:0]  echo_time,
  input logic [WIN_BITS-1:0] advertised_window,
  input logic                last
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_tag)
      && $stable(out_len) && $stable(ack_seq) && $stable(echo_time)
      && $stable(advertised_window) && $stable(last))
    else $error("stalled output beat changed");

  // a delivery is never the end of a reply, every other kind always is
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != KIND_DELIVER)))
    else $error("last flag does not match result kind");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DELIVER |-> out_tag == '0 && out_len == '0)
    else $error("non-delivery beat carries payload fields");

  a_win_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> advertised_window != '0)
    else $error("advertised window is zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind selective_repeat_receive_window_core srw_checker u_srw_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .kind              (kind),
  .out_tag           (out_tag),
  .out_len           (out_len),
  .ack_seq           (ack_seq),
  .echo_time         (echo_time),
  .advertised_window (advertised_window),
  .last              (last)
);

// ----- verif/srw_reply_checker.sv -----
`timescale 1ns / 1ps
module srw_reply_checker import srw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [WIN_BITS-1:0] cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [SEQ_BITS-1:0] seq_num,
  input  logic [LEN_BITS-1:0] payload_len,
  input  logic                truncated,
  input  logic [TAG_BITS-1:0] payload_tag,
  input  logic [TS_BITS-1:0]  timestamp,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          kind,
  input  logic [TAG_BITS-1:0] out_tag,
  input  logic [LEN_BITS-1:0] out_len,
  input  logic [SEQ_BITS-1:0] ack_seq,
  input  logic [TS_BITS-1:0]  echo_time,
  input  logic [WIN_BITS-1:0] advertised_window,
  input  logic                last,
  output int                  fail_count,
  output int                  pending
);

  localparam int STORE_DEPTH = 32;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [TS_BITS-1:0]  ts_t;
  typedef logic [WIN_BITS-1:0] win_t;

  typedef struct {
    kind_t kind;
    tag_t  tag;
    len_t  len;
    seq_t  seq;
    ts_t   ts;
    win_t  win;
    logic  last;
  } reply_t;

  reply_t reply_q[$];

  // receiver state as the block should hold it
  win_t                   win_reg;
  seq_t                   rx_next_seq;
  logic [4:0]             rx_head;
  logic [STORE_DEPTH-1:0] held;
  len_t                   held_len[STORE_DEPTH];
  tag_t                   held_tag[STORE_DEPTH];
  int                     mismatches = 0;

  function automatic reply_t make_reply(kind_t k, tag_t tag, len_t len, seq_t seq, ts_t ts,
                                        win_t win, logic fin);
    reply_t r;
    r.kind = k;
    r.tag  = tag;
    r.len  = len;
    r.seq  = seq;
    r.ts   = ts;
    r.win  = win;
    r.last = fin;
    return r;
  endfunction

  task automatic predict_reply();
    win_t       w;
    seq_t       offset;
    logic [4:0] slot;
    int         n;
    w = win_reg;
    if (w == '0) w = win_t'(1);
    n = 0;
    if (truncated) begin
      reply_q.push_back(make_reply(KIND_NACK, '0, '0, seq_num, timestamp, w, 1'b1));
    end else if (payload_len == '0) begin
      reply_q.push_back(make_reply(KIND_END, '0, '0, rx_next_seq, timestamp, w, 1'b1));
    end else begin
      offset = seq_num - rx_next_seq;
      if (int'(offset) < int'(w)) begin
        slot = rx_head + offset[4:0];
        held[slot] = 1'b1;
        held_len[slot] = payload_len;
        held_tag[slot] = payload_tag;
      end
      // in-order drain, capped so the ack still fits in one reply
      while (n < int'(DELIVER_LIMIT) && held[rx_head]) begin
        reply_q.push_back(make_reply(KIND_DELIVER, held_tag[rx_head], held_len[rx_head],
                                     rx_next_seq, timestamp, w, 1'b0));
        held[rx_head] = 1'b0;
        rx_head = rx_head + 1'b1;
        rx_next_seq = rx_next_seq + 1'b1;
        n++;
      end
      reply_q.push_back(make_reply(KIND_ACK, '0, '0, rx_next_seq, timestamp, w, 1'b1));
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      win_reg = RESET_WINDOW;
      rx_next_seq = '0;
      rx_head = '0;
      held = '0;
      reply_q.delete();
    end else begin
      if (cfg_wr_en) win_reg = cfg_wr_data;
      if (in_valid && !in_stall) predict_reply();
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual kind %0h ack_seq %0h",
                   $time, kind, ack_seq);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("out_tag", 32'(want.tag), 32'(out_tag));
          check_field("out_len", 32'(want.len), 32'(out_len));
          check_field("ack_seq", 32'(want.seq), 32'(ack_seq));
          check_field("echo_time", want.ts, echo_time);
          check_field("advertised_window", 32'(want.win), 32'(advertised_window));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
    pending <= reply_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- verif/tb_selective_repeat_receive_window_core.sv -----
`timescale 1ns / 1ps
module tb_selective_repeat_receive_window_core;
  import srw_pkg::*;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [TS_BITS-1:0]  ts_t;
  typedef logic [WIN_BITS-1:0] win_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [WIN_BITS-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SEQ_BITS-1:0] seq_num = '0;
  logic [LEN_BITS-1:0] payload_len = '0;
  logic                truncated = 1'b0;
  logic [TAG_BITS-1:0] payload_tag = '0;
  logic [TS_BITS-1:0]  timestamp = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          kind;
  logic [TAG_BITS-1:0] out_tag;
  logic [LEN_BITS-1:0] out_len;
  logic [SEQ_BITS-1:0] ack_seq;
  logic [TS_BITS-1:0]  echo_time;
  logic [WIN_BITS-1:0] advertised_window;
  logic                last;
  int                  fail_count;
  int                  pending;

  logic quiet = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   eff_win = 3;
  seq_t base_seq = '0;

  always #5 clk = ~clk;

  selective_repeat_receive_window_core dut (.*);

  srw_reply_checker reply_check (.*);

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 13);
    end
  end

  task automatic send_packet(input seq_t s, input len_t l, input logic tr, input tag_t tg,
                             input ts_t ts);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_num <= s;
    payload_len <= l;
    truncated <= tr;
    payload_tag <= tg;
    timestamp <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_data(input seq_t s);
    send_packet(s, len_t'($urandom_range(1, 1023)), 1'b0, tag_t'($urandom), ts_t'($urandom));
  endtask

  // packets that must not move the window: nacks, end markers, far offsets
  task automatic send_noise(input int b);
    case ($urandom_range(2))
      0: send_packet(seq_t'($urandom), len_t'($urandom), 1'b1, tag_t'($urandom),
                     ts_t'($urandom));
      1: send_packet(seq_t'($urandom), '0, 1'b0, tag_t'($urandom), ts_t'($urandom));
      default: send_data(seq_t'(int'(base_seq) + b + eff_win +
                                $urandom_range(0, 255 - b - eff_win)));
    endcase
  endtask

  task automatic wait_replies();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_window(input win_t w);
    in_valid <= 1'b0;
    wait_replies();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eff_win = (w == '0) ? 1 : int'(w);
  endtask

  // b consecutive numbers from base_seq in shuffled order, mixed with noise
  task automatic send_block(input int b, input bit base_last);
    seq_t order[32];
    seq_t t;
    int   i;
    int   j;
    for (i = 0; i < b; i++) order[i] = seq_t'(int'(base_seq) + i);
    for (i = b - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    if (base_last) begin
      for (i = 0; i < b; i++) begin
        if (order[i] == base_seq) begin
          order[i] = order[b-1];
          order[b-1] = base_seq;
        end
      end
    end
    for (i = 0; i < b; i++) begin
      if ($urandom_range(99) < 25) send_noise(b);
      send_data(order[i]);
      if ($urandom_range(99) < 8) send_data(order[$urandom_range(i)]);
    end
    base_seq = seq_t'(int'(base_seq) + b);
  endtask

  initial begin
    int   phase;
    int   blocks;
    int   k;
    win_t w;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset window of 3
    send_packet(8'd0, 10'd1, 1'b0, 16'h0000, 32'h0000_0000);
    send_packet(8'd2, 10'd512, 1'b0, 16'hffff, 32'hffff_ffff);
    send_packet(8'd3, 10'd1023, 1'b0, 16'h8001, 32'h8000_0001);
    send_packet(8'd4, 10'd9, 1'b0, 16'h0042, 32'h0000_0001);   // just past the window
    send_packet(8'd2, 10'd7, 1'b0, 16'h1234, 32'h0000_0002);   // overwrites held slot
    send_packet(8'd1, 10'd0, 1'b1, 16'h5555, 32'h0000_0003);   // truncated and empty
    send_packet(8'd255, 10'd1023, 1'b1, 16'haaaa, 32'h0000_0004);
    send_packet(8'd9, 10'd0, 1'b0, 16'h7777, 32'h0000_0005);
    send_packet(8'd1, 10'd1, 1'b0, 16'h0101, 32'h0000_0006);   // drains three
    send_packet(8'd0, 10'd5, 1'b0, 16'h0202, 32'h0000_0007);   // behind the window

    // zero window behaves as one
    set_window(5'd0);
    send_packet(8'd5, 10'd3, 1'b0, 16'h0303, 32'h0000_0008);
    send_packet(8'd4, 10'd4, 1'b0, 16'h0404, 32'h0000_0009);
    send_packet(8'd5, 10'd5, 1'b0, 16'h0505, 32'h0000_000a);

    // fill with a wide window, then shrink it under the held slots
    set_window(5'd31);
    send_packet(8'd8, 10'd8, 1'b0, 16'h0808, 32'h0000_000b);
    send_packet(8'd9, 10'd9, 1'b0, 16'h0909, 32'h0000_000c);
    send_packet(8'd10, 10'd10, 1'b0, 16'h0a0a, 32'h0000_000d);
    set_window(5'd1);
    send_packet(8'd7, 10'd11, 1'b0, 16'h0b0b, 32'h0000_000e);
    send_packet(8'd6, 10'd12, 1'b0, 16'h0c0c, 32'h0000_000f);
    send_packet(8'd7, 10'd13, 1'b0, 16'h0d0d, 32'h0000_0010);
    base_seq = 8'd11;

    phase = 0;
    while (items_sent < 300) begin
      case (phase % 4)
        0: w = 5'd31;
        1: w = 5'd1;
        2: w = win_t'($urandom_range(2, 30));
        default: w = win_t'($urandom_range(0, 31));
      endcase
      set_window(w);
      quiet <= (phase == 2);
      if (phase == 4) hold_req <= hold_req + 1;
      blocks = $urandom_range(2, 4);
      for (k = 0; k < blocks; k++) begin
        // whole window held back until its first packet: longest reply
        if (phase % 4 == 0 && k == 0) send_block(31, 1'b1);
        else send_block($urandom_range(1, (eff_win < 8) ? eff_win : 8), 1'b0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait_replies();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/srw_pkg.sv
hw/rtl/srw_front.sv
hw/rtl/srw_queue.sv
hw/rtl/srw_back.sv
hw/rtl/selective_repeat_receive_window_core.sv
hw/rtl/srw_checker.sv
verif/srw_reply_checker.sv
verif/tb_selective_repeat_receive_window_core.sv
